FILE: src/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
`default_nettype none
package rau_pkg;
	localparam int OPERAND_WIDTH_DEF = 32;
	localparam int CMD_W = 3;
	localparam int RES_W = 64;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD   = 3'd0,
		CMD_SUB   = 3'd1,
		CMD_MUL   = 3'd2,
		CMD_DIV   = 3'd3,
		CMD_NORM  = 3'd4,
		CMD_RECIP = 3'd5,
		CMD_NEG   = 3'd6,
		CMD_CMP   = 3'd7
	} cmd_t;

	// request to the shared divider
	typedef struct packed {
		logic start;
	} div_ctl_t;
endpackage
`default_nettype wire

FILE: src/rational_arithmetic_unit_top.sv
// Top level: command decode, shared multiplier, gcd sequencer and result register.
//
// channel  | direction | handshake    | payload
// command  | in        | start / busy | cmd, a_num, a_den, b_num, b_den
// result   | out       | done strobe  | res_num, res_den, cmp_sign, error
//
// Add, subtract, multiply, divide, compare: passes through one 32x32
// signed multiplier used once per cycle. Negate, reciprocal: set in the first pass.
// Normalize: gcd by repeated remainder on the shared bit-serial divider
// (up to about 1.5*W steps) then two divides by the gcd.
// busy is high from acceptance until the done cycle; no stall on the result side.
`default_nettype none
module rational_arithmetic_unit_top #(
	parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  cmd,
	input  wire logic signed [31:0] a_num,
	input  wire logic signed [31:0] a_den,
	input  wire logic signed [31:0] b_num,
	input  wire logic signed [31:0] b_den,
	output logic             done,
	output logic signed [63:0] res_num,
	output logic signed [63:0] res_den,
	output logic signed [1:0]  cmp_sign,
	output logic             error
);
	localparam int W = OPERAND_WIDTH;

	typedef enum logic [3:0] {
		ST_IDLE, ST_M1, ST_M2, ST_M3, ST_FIN, ST_GCD_GO, ST_GCD_WAIT,
		ST_DN_GO, ST_DN_WAIT, ST_DD_GO, ST_DD_WAIT, ST_OUT
	} state_t;

	state_t state_q;
	rau_pkg::cmd_t cmd_q;
	logic signed [W-1:0] an_q, ad_q, bn_q, bd_q;
	logic signed [63:0]  p0_q, p1_q;
	logic signed [W-1:0] ma, mb;
	logic signed [2*W-1:0] prod;
	logic [1:0] msel_q;
	logic signed [64:0] sum;
	logic neg_q;
	logic [W-1:0] gx_q, gy_q, g_q, mn_q;
	rau_pkg::div_ctl_t dctl;
	logic [W-1:0] dvd, dvs, dq, dr;
	logic ddone;

	// operand pairs for the shared multiplier
	always_comb begin
		case (msel_q)
			2'd0:    begin ma = an_q; mb = bd_q; end
			2'd1:    begin ma = bn_q; mb = ad_q; end
			2'd2:    begin ma = an_q; mb = bn_q; end
			default: begin ma = ad_q; mb = bd_q; end
		endcase
	end
	assign prod = ma * mb;

	always_comb begin
		if (cmd_q == rau_pkg::CMD_SUB) sum = {p0_q[63], p0_q} - {p1_q[63], p1_q};
		else                           sum = {p0_q[63], p0_q} + {p1_q[63], p1_q};
	end

	always_comb begin
		dctl.start = (state_q == ST_GCD_GO) || (state_q == ST_DN_GO)
			|| (state_q == ST_DD_GO);
		case (state_q)
			ST_DN_GO: begin dvd = mn_q; dvs = g_q; end
			ST_DD_GO: begin dvd = gy_q; dvs = g_q; end
			default:  begin dvd = gx_q; dvs = gy_q; end
		endcase
	end

	rau_div #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .ctl(dctl), .dividend(dvd), .divisor(dvs),
		.done(ddone), .quot(dq), .rem(dr)
	);

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done     <= 1'b0;
			error    <= 1'b0;
			res_num  <= '0;
			res_den  <= 64'sd1;
			cmp_sign <= '0;
			msel_q   <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: if (start) begin
					cmd_q  <= rau_pkg::cmd_t'(cmd);
					an_q   <= a_num[W-1:0];
					ad_q   <= a_den[W-1:0];
					bn_q   <= b_num[W-1:0];
					bd_q   <= b_den[W-1:0];
					msel_q <= 2'd0;
					state_q <= ST_M1;
				end
				ST_M1: begin
					// first pass: error checks, then select pair 0 or 2 for the first product
					if (ad_q == '0 || ((cmd_q inside {rau_pkg::CMD_ADD, rau_pkg::CMD_SUB,
						rau_pkg::CMD_MUL, rau_pkg::CMD_DIV, rau_pkg::CMD_CMP})
						&& bd_q == '0) || (cmd_q == rau_pkg::CMD_DIV && bn_q == '0)
						|| (cmd_q == rau_pkg::CMD_RECIP && an_q == '0)) begin
						res_num <= '0; res_den <= 64'sd1; cmp_sign <= '0; error <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						error <= 1'b0; cmp_sign <= '0;
						case (cmd_q)
							rau_pkg::CMD_RECIP: begin
								res_num <= 64'(ad_q); res_den <= 64'(an_q); state_q <= ST_OUT;
							end
							rau_pkg::CMD_NEG: begin
								res_num <= -64'(an_q); res_den <= 64'(ad_q); state_q <= ST_OUT;
							end
							rau_pkg::CMD_NORM: begin
								if (an_q == '0) begin
									res_num <= '0; res_den <= 64'sd1; state_q <= ST_OUT;
								end else begin
									neg_q <= an_q[W-1] ^ ad_q[W-1];
									mn_q  <= an_q[W-1] ? W'(-an_q) : an_q;
									gx_q  <= an_q[W-1] ? W'(-an_q) : an_q;
									gy_q  <= ad_q[W-1] ? W'(-ad_q) : ad_q;
									g_q   <= ad_q[W-1] ? W'(-ad_q) : ad_q;
									state_q <= ST_GCD_GO;
								end
							end
							default: begin
								msel_q  <= (cmd_q == rau_pkg::CMD_MUL) ? 2'd2 : 2'd0;
								state_q <= ST_M2;
							end
						endcase
					end
				end
				ST_M2: begin
					p0_q <= 64'(prod);
					msel_q <= (cmd_q == rau_pkg::CMD_MUL) ? 2'd3
						: (cmd_q == rau_pkg::CMD_DIV) ? 2'd1 : 2'd1;
					state_q <= ST_M3;
				end
				ST_M3: begin
					p1_q <= 64'(prod);
					msel_q <= 2'd3;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					case (cmd_q)
						rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
							if (sum[64] != sum[63]) begin
								res_num <= '0; res_den <= 64'sd1; error <= 1'b1;
							end else begin
								res_num <= sum[63:0]; res_den <= 64'(prod);
							end
						end
						rau_pkg::CMD_MUL: begin
							res_num <= p0_q; res_den <= p1_q;
						end
						rau_pkg::CMD_DIV: begin
							// a_num*b_den over a_den*b_num
							res_num <= p0_q; res_den <= p1_q;
						end
						default: begin
							res_num <= '0; res_den <= 64'sd1;
							if (p1_q == p0_q) cmp_sign <= 2'sd0;
							else if ((p1_q > p0_q) ^ (ad_q[W-1] ^ bd_q[W-1]))
								cmp_sign <= 2'sd1;
							else cmp_sign <= -2'sd1;
						end
					endcase
					state_q <= ST_OUT;
				end
				ST_GCD_GO: state_q <= ST_GCD_WAIT;
				ST_GCD_WAIT: if (ddone) begin
					if (dr == '0) begin
						g_q <= gy_q; gy_q <= g_q; state_q <= ST_DN_GO;
					end else begin
						gx_q <= gy_q; gy_q <= dr; state_q <= ST_GCD_GO;
					end
				end
				ST_DN_GO: state_q <= ST_DN_WAIT;
				ST_DN_WAIT: if (ddone) begin
					res_num <= neg_q ? -{{(64-W){1'b0}}, dq} : {{(64-W){1'b0}}, dq};
					state_q <= ST_DD_GO;
				end
				ST_DD_GO: state_q <= ST_DD_WAIT;
				ST_DD_WAIT: if (ddone) begin
					res_den <= {{(64-W){1'b0}}, dq};
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					done <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: src/rau_div.sv
// Restoring divider, one quotient bit per cycle, used for gcd and reduction.
`default_nettype none
module rau_div #(
	parameter int W = rau_pkg::OPERAND_WIDTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire rau_pkg::div_ctl_t ctl,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic [W-1:0]      quot,
	output logic [W-1:0]      rem
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  q_q, r_q, d_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic [W:0]    trial;
	logic [W:0]    shifted;

	assign shifted = {r_q, q_q[W-1]};
	assign trial   = shifted - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (ctl.start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W);
				q_q   <= dividend;
				r_q   <= '0;
				d_q   <= divisor;
			end else if (run_q) begin
				if (trial[W]) begin
					r_q <= shifted[W-1:0];
					q_q <= {q_q[W-2:0], 1'b0};
				end else begin
					r_q <= trial[W-1:0];
					q_q <= {q_q[W-2:0], 1'b1};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	assign quot = q_q;
	assign rem  = r_q;
endmodule
`default_nettype wire
